// ===== hw/rtl/lfp_pkg.sv =====
// shared types and constants for the lidar frame parser
`default_nettype none

package lfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h59;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HEADER   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_NO_DATA  = 2'd3;

    localparam logic       ACT_BYTE    = 1'b0;
    localparam logic       ACT_TIMEOUT = 1'b1;

    localparam logic       CFG_MAX_SKIP = 1'b0;
    localparam logic       CFG_MAX_FAIL = 1'b1;

    localparam int RES_BITS   = 51;
    localparam int OUT_TDATA_W = 56;

    typedef struct packed {
        logic        retry_limit_hit;
        logic [15:0] temperature;
        logic [15:0] strength;
        logic [15:0] distance;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/lfp_frame_core.sv =====
// header hunt, field capture, checksum and failure counting, one byte per cycle while i_accept is high
`default_nettype none

module lfp_frame_core
    import lfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_action,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_max_skip,
    input  wire logic [7:0] i_max_fail,
    output logic            o_res_valid,
    output t_result         o_result
);

    logic [7:0]  r_prev_byte, n_prev_byte;
    logic        r_in_frame, n_in_frame;
    logic [3:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_sum, n_sum;
    logic [8:0]  r_skip_cnt, n_skip_cnt;
    logic [47:0] r_fields, n_fields;
    logic [8:0]  r_fail_cnt, n_fail_cnt;

    logic        finish;
    logic [1:0]  fin_status;
    logic [8:0]  skip_inc;
    logic [8:0]  fail_inc;

    always_comb begin
        n_prev_byte = r_prev_byte;
        n_in_frame  = r_in_frame;
        n_byte_pos  = r_byte_pos;
        n_sum       = r_sum;
        n_skip_cnt  = r_skip_cnt;
        n_fields    = r_fields;
        n_fail_cnt  = r_fail_cnt;
        finish      = 1'b0;
        fin_status  = ST_OK;
        skip_inc    = r_skip_cnt + 9'd1;
        fail_inc    = r_fail_cnt + 9'd1;
        o_result    = '0;

        if (i_accept) begin
            if (i_action == ACT_TIMEOUT) begin
                finish     = 1'b1;
                fin_status = ST_NO_DATA;
            end else if (!r_in_frame) begin
                if (r_prev_byte == HEADER_BYTE && i_rx_byte == HEADER_BYTE) begin
                    n_in_frame = 1'b1;
                    n_byte_pos = 4'd2;
                    n_sum      = HEADER_BYTE + HEADER_BYTE;
                end else begin
                    n_prev_byte = i_rx_byte;
                    n_skip_cnt  = skip_inc;
                    if (skip_inc > {1'b0, i_max_skip}) begin
                        finish     = 1'b1;
                        fin_status = ST_HEADER;
                    end
                end
            end else if (r_byte_pos <= 4'd7) begin
                case (r_byte_pos)
                    4'd2:    n_fields[7:0]   = i_rx_byte;
                    4'd3:    n_fields[15:8]  = i_rx_byte;
                    4'd4:    n_fields[23:16] = i_rx_byte;
                    4'd5:    n_fields[31:24] = i_rx_byte;
                    4'd6:    n_fields[39:32] = i_rx_byte;
                    4'd7:    n_fields[47:40] = i_rx_byte;
                    default: n_fields        = r_fields;
                endcase
                n_sum      = r_sum + i_rx_byte;
                n_byte_pos = r_byte_pos + 4'd1;
            end else begin
                finish     = 1'b1;
                fin_status = (r_sum == i_rx_byte) ? ST_OK : ST_CHECKSUM;
            end
        end

        if (finish) begin
            o_result.status = fin_status;
            if (fin_status == ST_OK) begin
                n_fail_cnt           = '0;
                o_result.distance    = r_fields[15:0];
                o_result.strength    = r_fields[31:16];
                o_result.temperature = r_fields[47:32];
            end else if (fail_inc > {1'b0, i_max_fail}) begin
                n_fail_cnt               = '0;
                o_result.retry_limit_hit = 1'b1;
            end else begin
                n_fail_cnt = fail_inc;
            end
            n_prev_byte = '0;
            n_in_frame  = 1'b0;
            n_byte_pos  = '0;
            n_sum       = '0;
            n_skip_cnt  = '0;
        end
    end

    assign o_res_valid = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte <= '0;
            r_in_frame  <= 1'b0;
            r_byte_pos  <= '0;
            r_sum       <= '0;
            r_skip_cnt  <= '0;
            r_fail_cnt  <= '0;
        end else begin
            r_prev_byte <= n_prev_byte;
            r_in_frame  <= n_in_frame;
            r_byte_pos  <= n_byte_pos;
            r_sum       <= n_sum;
            r_skip_cnt  <= n_skip_cnt;
            r_fail_cnt  <= n_fail_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
    end

    a_ok_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.status == ST_OK) |-> !o_result.retry_limit_hit)
        else $error("retry limit flag raised on a good frame");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_byte_pos >= 4'd2 && r_byte_pos <= 4'd8))
        else $error("byte position out of frame range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (!r_in_frame && r_skip_cnt == 9'd0 && r_prev_byte == 8'd0))
        else $error("hunt not restarted after a result");

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_byte_pos == 4'd0)
        else $error("byte position set while hunting");

endmodule

`default_nettype wire

// ===== hw/rtl/lfp_out_skid.sv =====
// result register with one skid entry
`default_nettype none

module lfp_out_skid
    import lfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty result register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed while skid entry full");

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_frame_parser.sv =====
// top level of the nine-byte lidar frame parser
//
// channel  dir  handshake                 payload
// s        in   i_s_tvalid / o_s_tready   tdata: rx_byte; tuser: action
// m        out  o_m_tvalid / i_m_tready   tdata: status, distance, strength,
//                                         temperature, retry_limit_hit
// cfg      in   i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// one transfer per cycle while o_s_tready is high; a result is registered, in the result
// register or else the skid entry, from the byte or timeout that ends the attempt
// a one-entry skid behind the result register keeps o_s_tready registered
// o_s_tready drops only while both result entries are full
// synchronous active-low reset clears hunt state, counters and the result path
`default_nettype none

module lidar_frame_parser
    import lfp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,   // [7:0] rx_byte
    input  wire logic                   i_s_tuser,   // [0] action
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [1:0] status, [17:2] distance,
                                                     // [33:18] strength,
                                                     // [49:34] temperature,
                                                     // [50] retry_limit_hit
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [7:0]             i_cfg_wdata
);

    logic [7:0] r_max_skip;
    logic [7:0] r_max_fail;
    logic       accept;
    logic       res_valid;
    t_result    result;
    t_result    out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_skip <= 8'd20;
            r_max_fail <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_SKIP: r_max_skip <= i_cfg_wdata;
                CFG_MAX_FAIL: r_max_fail <= i_cfg_wdata;
                default:      r_max_skip <= r_max_skip;
            endcase
        end
    end

    assign accept = i_s_tvalid && o_s_tready;

    lfp_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_s_tuser),
        .i_rx_byte   (i_s_tdata),
        .i_max_skip  (r_max_skip),
        .i_max_fail  (r_max_fail),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    lfp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (result),
        .o_space (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_data)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - RES_BITS){1'b0}}, out_data};

endmodule

`default_nettype wire

// ===== tb/tb_lidar_frame_parser.sv =====
// testbench for lidar_frame_parser: byte and timeout streams checked against a frame predictor
`timescale 1ns / 1ps

module tb_lidar_frame_parser
    import lfp_pkg::*;
();

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = ACT_BYTE;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = CFG_MAX_SKIP;
    logic [7:0]             cfg_wdata = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // frame parser state as seen from outside
    logic [7:0]  lim_skip = 8'd20;
    logic [7:0]  lim_fail = 8'd10;
    logic [7:0]  hunt_prev = '0;
    logic        in_frame = 1'b0;
    logic [3:0]  frame_pos = '0;
    logic [7:0]  frame_sum = '0;
    logic [8:0]  skip_count = '0;
    logic [47:0] frame_body = '0;
    logic [8:0]  fail_count = '0;

    t_result frame_reports[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;
    bit      hold_req = 1'b0;

    lidar_frame_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] rx_byte
        .i_s_tuser  (s_tuser),    // [0] action
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // [1:0] status, [17:2] distance, [33:18] strength,
                                  // [49:34] temperature, [50] retry_limit_hit
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= HEADER_BYTE)
            b = b + 8'd1;
        return b;
    endfunction

    task automatic close_attempt(input logic [1:0] st);
        t_result r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            fail_count = '0;
            r.distance = frame_body[15:0];
            r.strength = frame_body[31:16];
            r.temperature = frame_body[47:32];
        end else begin
            fail_count = fail_count + 9'd1;
            if (fail_count > {1'b0, lim_fail}) begin
                r.retry_limit_hit = 1'b1;
                fail_count = '0;
            end
        end
        frame_reports.push_back(r);
        hunt_prev = '0;
        in_frame = 1'b0;
        frame_pos = '0;
        frame_sum = '0;
        skip_count = '0;
    endtask

    task automatic parse_item(input logic act, input logic [7:0] b);
        if (act == ACT_TIMEOUT) begin
            close_attempt(ST_NO_DATA);
        end else if (!in_frame) begin
            if (hunt_prev == HEADER_BYTE && b == HEADER_BYTE) begin
                in_frame = 1'b1;
                frame_pos = 4'd2;
                frame_sum = HEADER_BYTE + HEADER_BYTE;
                frame_body = '0;
            end else begin
                hunt_prev = b;
                skip_count = skip_count + 9'd1;
                if (skip_count > {1'b0, lim_skip})
                    close_attempt(ST_HEADER);
            end
        end else if (frame_pos <= 4'd7) begin
            frame_body[(frame_pos - 2) * 8 +: 8] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            close_attempt(frame_sum == b ? ST_OK : ST_CHECKSUM);
        end
    endtask

    // called at a rising edge; returns at the edge of the transfer with tvalid still high
    task automatic drive_rx(input logic act, input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= act;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
        parse_item(act, b);
    endtask

    task automatic send_frame(input logic [47:0] body, input bit corrupt);
        logic [7:0] sum;
        sum = HEADER_BYTE + HEADER_BYTE;
        drive_rx(ACT_BYTE, HEADER_BYTE);
        drive_rx(ACT_BYTE, HEADER_BYTE);
        for (int i = 0; i < 6; i++) begin
            drive_rx(ACT_BYTE, body[i * 8 +: 8]);
            sum = sum + body[i * 8 +: 8];
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        drive_rx(ACT_BYTE, sum);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frame_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [7:0] skip_lim, input logic [7:0] fail_lim);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_SKIP;
        cfg_wdata <= skip_lim;
        @(posedge i_clk);
        cfg_index <= CFG_MAX_FAIL;
        cfg_wdata <= fail_lim;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lim_skip = skip_lim;
        lim_fail = fail_lim;
    endtask

    task automatic send_random_traffic(input int n);
        int          stop_at;
        int          pick;
        logic [47:0] body;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                repeat ($urandom_range(0, 2)) drive_rx(ACT_BYTE, noise_byte());
                body[31:0] = $urandom();
                body[47:32] = 16'($urandom());
                send_frame(body, $urandom_range(0, 99) < 15);
            end else if (pick < 77) begin
                // frame cut short by a read timeout
                drive_rx(ACT_BYTE, HEADER_BYTE);
                drive_rx(ACT_BYTE, HEADER_BYTE);
                repeat ($urandom_range(0, 6)) drive_rx(ACT_BYTE, 8'($urandom_range(0, 255)));
                drive_rx(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 30)) drive_rx(ACT_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                drive_rx(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
            end else begin
                drive_rx(ACT_BYTE, HEADER_BYTE);
                drive_rx(ACT_BYTE, noise_byte());
            end
        end
    endtask

    task automatic test_directed();
        send_frame(48'hFFFF_0000_FFFF, 1'b0);
        send_frame(48'h0000_FFFF_0000, 1'b1);
        // timeout in the middle of a frame, rx_byte ignored
        drive_rx(ACT_BYTE, HEADER_BYTE);
        drive_rx(ACT_BYTE, HEADER_BYTE);
        drive_rx(ACT_BYTE, 8'hA5);
        drive_rx(ACT_TIMEOUT, 8'hFF);
        // timeout while hunting
        drive_rx(ACT_TIMEOUT, 8'h00);
        // header byte repeated three times, third one is data
        drive_rx(ACT_BYTE, HEADER_BYTE);
        send_frame(48'h5959_5959_5959, 1'b0);
    endtask

    task automatic test_zero_limits();
        set_limits(8'd0, 8'd0);
        // lone header byte after a result never matches
        drive_rx(ACT_BYTE, HEADER_BYTE);
        drive_rx(ACT_BYTE, 8'h00);
        drive_rx(ACT_BYTE, 8'hFF);
        drive_rx(ACT_TIMEOUT, 8'h5A);
        send_random_traffic(40);
    endtask

    task automatic test_limit_extremes();
        set_limits(8'd255, 8'd255);
        drive_rx(ACT_TIMEOUT, 8'h00);
        send_frame(48'h0000_0000_0000, 1'b0);
        repeat (256) drive_rx(ACT_BYTE, noise_byte());
        repeat (255) drive_rx(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
        send_random_traffic(30);
    endtask

    task automatic test_random_settings();
        logic [7:0] skips[4];
        logic [7:0] fails[4];
        skips = '{8'd3, 8'd1, 8'd255, 8'($urandom_range(0, 255))};
        fails = '{8'd2, 8'd255, 8'd0, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 4; i++) begin
            set_limits(skips[i], fails[i]);
            send_random_traffic(60);
        end
    endtask

    task automatic test_backpressure();
        set_limits(8'd20, 8'd10);
        quiet = 1'b1;
        hold_req = 1'b1;
        send_random_traffic(200);
        wait_idle();
        quiet = 1'b0;
        send_random_traffic(200);
    endtask

    initial begin : result_sink
        int dur;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                dur = HOLD_CYCLES;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                dur = quiet ? 1 : $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b0;
                dur = 1 + idle_gap();
            end
            repeat (dur) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata[RES_BITS-1:0];
            if (frame_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = frame_reports.pop_front();
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("distance", want.distance, got.distance);
                check_field("strength", want.strength, got.strength);
                check_field("temperature", want.temperature, got.temperature);
                check_field("retry_limit_hit", 16'(want.retry_limit_hit),
                            16'(got.retry_limit_hit));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_lidar_frame_parser: errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_limits();
        test_limit_extremes();
        test_random_settings();
        test_backpressure();
        wait_idle();
        if (mismatches == 0 && frame_reports.size() == 0)
            $display("tb_lidar_frame_parser: clean");
        else
            $display("tb_lidar_frame_parser: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lfp_pkg.sv
hw/rtl/lfp_frame_core.sv
hw/rtl/lfp_out_skid.sv
hw/rtl/lidar_frame_parser.sv
tb/tb_lidar_frame_parser.sv
